FILE: hw/rtl/utf8_char_framer_newline_norm_unit_macros.svh
// Assertion macros shared by the UTF-8 framer RTL.
`ifndef UTF8_CHAR_FRAMER_NEWLINE_NORM_UNIT_MACROS_SVH
`define UTF8_CHAR_FRAMER_NEWLINE_NORM_UNIT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define U8FNN_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define U8FNN_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/u8fnn_pkg.sv
// Shared types, constants and functions of the UTF-8 framer.
`default_nettype none
package u8fnn_pkg;

	// Default longest sequence a lead byte may announce.
	localparam int MAX_SEQ_BYTES_DEF = 8;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// Byte classes.
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	// Byte order mark, first byte first.
	localparam logic [7:0] BOM_B0 = 8'hEF;
	localparam logic [7:0] BOM_B1 = 8'hBB;
	localparam logic [7:0] BOM_B2 = 8'hBF;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_NEWLINE = 2'd1,
		KIND_INVALID = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// One queue entry: the results caused by one request.
	// With two_res set, an invalid result precedes the end result.
	typedef struct packed {
		logic        two_res;
		kind_t       kind;
		logic [63:0] bytes;
		logic [3:0]  len;
	} entry_t;

	// Length of the run of one bits from the top of a byte.
	function automatic logic [3:0] leading_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		begin
			n = 4'd0;
			run = 1'b1;
			for (int i = 7; i >= 0; i--) begin
				if (run && b[i]) begin
					n = n + 4'd1;
				end else begin
					run = 1'b0;
				end
			end
			return n;
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/u8fnn_front.sv
// Front part: classifies each byte, tracks the open sequence and builds queue entries.
`default_nettype none
module u8fnn_front #(
	parameter int MAX_SEQUENCE_BYTES = u8fnn_pkg::MAX_SEQ_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      byte_value,
	input  wire logic            end_of_stream,
	output u8fnn_pkg::entry_t    push_data,
	output logic                 push
);

	localparam int GW = 8 * MAX_SEQUENCE_BYTES;

	logic [GW-1:0] gath_q, gath_new, gath_nxt;
	logic [3:0]    exp_q, exp_nxt;
	logic [3:0]    seen_q, seen_nxt, seen_inc;
	logic          bad_q, bad_nxt, bad_new;
	logic          cr_q, cr_nxt;
	logic          seq_open, is_cont, is_ascii, store, seq_done, is_bom;
	logic          want_push;
	logic [3:0]    run;

	// Byte classification.
	assign seq_open = (exp_q != 4'd0);
	assign is_cont  = byte_value inside {[u8fnn_pkg::CONT_LO : u8fnn_pkg::CONT_HI]};
	assign is_ascii = (byte_value <= u8fnn_pkg::ASCII_MAX);
	assign run      = u8fnn_pkg::leading_ones(byte_value);
	assign seen_inc = seen_q + 4'd1;
	assign store    = seq_open && is_cont && !bad_q;
	assign bad_new  = bad_q || !is_cont;
	assign seq_done = seq_open && (seen_inc >= exp_q);

	// Merge a continuation byte into its lane of the open sequence.
	always_comb begin
		gath_new = gath_q;
		for (int i = 0; i < MAX_SEQUENCE_BYTES; i++) begin
			if (store && (seen_q == 4'(i))) begin
				gath_new[i*8 +: 8] = byte_value;
			end
		end
	end

	assign is_bom = (exp_q == 4'd3) &&
		(gath_new == GW'({u8fnn_pkg::BOM_B2, u8fnn_pkg::BOM_B1, u8fnn_pkg::BOM_B0}));

	// Next state and the entry for this request.
	always_comb begin
		gath_nxt = gath_q;
		exp_nxt = exp_q;
		seen_nxt = seen_q;
		bad_nxt = bad_q;
		cr_nxt = 1'b0;
		want_push = 1'b0;
		push_data.two_res = 1'b0;
		push_data.kind = u8fnn_pkg::KIND_CHAR;
		push_data.bytes = 64'd0;
		push_data.len = 4'd0;
		if (end_of_stream) begin
			want_push = 1'b1;
			push_data.two_res = seq_open;
			push_data.kind = u8fnn_pkg::KIND_END;
			gath_nxt = '0;
			exp_nxt = 4'd0;
			seen_nxt = 4'd0;
			bad_nxt = 1'b0;
		end else if (cr_q && (byte_value == u8fnn_pkg::CHAR_LF)) begin
			// The LF of a CR LF pair is dropped.
			want_push = 1'b0;
		end else if (seq_open) begin
			gath_nxt = gath_new;
			seen_nxt = seen_inc;
			bad_nxt = bad_new;
			if (seq_done) begin
				gath_nxt = '0;
				exp_nxt = 4'd0;
				seen_nxt = 4'd0;
				bad_nxt = 1'b0;
				if (bad_new) begin
					want_push = 1'b1;
					push_data.kind = u8fnn_pkg::KIND_INVALID;
				end else if (!is_bom) begin
					want_push = 1'b1;
					push_data.kind = u8fnn_pkg::KIND_CHAR;
					push_data.bytes = 64'(gath_new);
					push_data.len = exp_q;
				end
			end
		end else if (is_cont) begin
			// A stray continuation byte.
			want_push = 1'b1;
			push_data.kind = u8fnn_pkg::KIND_INVALID;
		end else if (is_ascii) begin
			want_push = 1'b1;
			if (byte_value == u8fnn_pkg::CHAR_CR) begin
				cr_nxt = 1'b1;
				push_data.kind = u8fnn_pkg::KIND_NEWLINE;
			end else if (byte_value == u8fnn_pkg::CHAR_LF) begin
				push_data.kind = u8fnn_pkg::KIND_NEWLINE;
			end else begin
				push_data.kind = u8fnn_pkg::KIND_CHAR;
				push_data.bytes = {56'd0, byte_value};
				push_data.len = 4'd1;
			end
		end else begin
			// A lead byte opens a sequence.
			gath_nxt = {{(GW-8){1'b0}}, byte_value};
			exp_nxt = run;
			seen_nxt = 4'd1;
			bad_nxt = (run > 4'(MAX_SEQUENCE_BYTES));
		end
	end

	assign push = accept && want_push;

	// State registers update on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gath_q <= '0;
			exp_q <= 4'd0;
			seen_q <= 4'd0;
			bad_q <= 1'b0;
			cr_q <= 1'b0;
		end else if (accept) begin
			gath_q <= gath_nxt;
			exp_q <= exp_nxt;
			seen_q <= seen_nxt;
			bad_q <= bad_nxt;
			cr_q <= cr_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/u8fnn_queue.sv
// Short queue of entries between the front and back parts.
`default_nettype none
module u8fnn_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u8fnn_pkg::entry_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output u8fnn_pkg::entry_t      pop_data,
	output logic                   empty
);

	localparam int DEPTH = u8fnn_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(DEPTH);

	u8fnn_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;

	assign full = (count_q == (PW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/u8fnn_back.sv
// Back part: turns queue entries into results in an output register.
`default_nettype none
module u8fnn_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire u8fnn_pkg::entry_t pop_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             kind,
	output logic [63:0]            char_bytes,
	output logic [3:0]             char_len,
	output logic                   last
);

	logic              valid_q, second_q, last_q;
	u8fnn_pkg::kind_t  kind_q;
	logic [63:0]       bytes_q;
	logic [3:0]        len_q;
	logic              load;

	// The output register takes a new result when empty or being taken.
	assign load = !valid_q || out_ready;
	assign pop = load && !second_q && !empty;

	// Control part of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q <= 1'b1;
				second_q <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				second_q <= pop_data.two_res;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload part of the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				kind_q <= u8fnn_pkg::KIND_END;
				bytes_q <= 64'd0;
				len_q <= 4'd0;
				last_q <= 1'b1;
			end else if (pop_data.two_res) begin
				kind_q <= u8fnn_pkg::KIND_INVALID;
				bytes_q <= 64'd0;
				len_q <= 4'd0;
				last_q <= 1'b0;
			end else begin
				kind_q <= pop_data.kind;
				bytes_q <= pop_data.bytes;
				len_q <= pop_data.len;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign kind = kind_q;
	assign char_bytes = bytes_q;
	assign char_len = len_q;
	assign last = last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_char_framer_newline_norm_unit.sv
// Top level of the UTF-8 character framer with newline normalization.
// Input channel: in_valid/in_ready carry one byte_value per request, or an
// end_of_stream mark. Output channel: out_valid/out_ready carry one result
// (kind, char_bytes, char_len, last); last marks the final result of a request.
// The front part decodes each byte in the cycle it is accepted and writes at
// most one entry to a four-deep queue; the back part moves entries into the
// output register. A result is loaded into the output register from the queue
// once that register is free. One byte is accepted per cycle while the queue
// is not full; an end mark inside an open sequence yields two results.
// Bytes that complete nothing (leads, continuations, the LF of CR LF, a
// byte order mark) give no result.
// When the receiver stalls, the output register holds and the queue fills;
// in_ready falls once the queue is full.
// Reset clears the sequence state, the CR flag, the queue and the output
// valid; an end mark clears the sequence state and the CR flag likewise.
`default_nettype none
`include "utf8_char_framer_newline_norm_unit_macros.svh"
module utf8_char_framer_newline_norm_unit #(
	parameter int MAX_SEQUENCE_BYTES = u8fnn_pkg::MAX_SEQ_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   byte_value,
	input  wire logic         end_of_stream,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        kind,
	output logic [63:0]       char_bytes,
	output logic [3:0]        char_len,
	output logic              last
);

	u8fnn_pkg::entry_t push_data, pop_data;
	logic              push, pop, full, empty, accept;

	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	// Decode and sequence tracking.
	u8fnn_front #(
		.MAX_SEQUENCE_BYTES(MAX_SEQUENCE_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_value   (byte_value),
		.end_of_stream(end_of_stream),
		.push_data    (push_data),
		.push         (push)
	);

	// Decoupling queue.
	u8fnn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	// Result output.
	u8fnn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.char_bytes(char_bytes),
		.char_len  (char_len),
		.last      (last)
	);

	// Only a character result carries bytes and a length.
	`U8FNN_ASSERT_SAME(a_nonchar_empty, out_valid && (kind != u8fnn_pkg::KIND_CHAR), (char_len == 4'd0) && (char_bytes == 64'd0), "non-character result carries bytes")
	// A character result has a length within the configured maximum.
	`U8FNN_ASSERT_SAME(a_char_len, out_valid && (kind == u8fnn_pkg::KIND_CHAR), (char_len != 4'd0) && (char_len <= 4'(MAX_SEQUENCE_BYTES)), "character length out of range")
	// Only the invalid result of an end mark can be followed by another result.
	`U8FNN_ASSERT_SAME(a_first_invalid, out_valid && !last, kind == u8fnn_pkg::KIND_INVALID, "non-last result is not invalid")
	// The end result follows directly after that invalid result.
	`U8FNN_ASSERT_NEXT(a_end_follows, out_valid && out_ready && !last, out_valid && last && (kind == u8fnn_pkg::KIND_END), "end result missing after invalid")

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the UTF-8 character framer with newline normalization.
`timescale 1ns / 100ps

module testbench;

	localparam int SEQ_MAX = u8fnn_pkg::MAX_SEQ_BYTES_DEF;

	// One byte request waiting to be offered, with the idle cycles before it.
	typedef struct {
		logic [7:0] value;
		logic       eos;
		int         gap;
	} feed_t;

	// One framed result as the block should deliver it.
	typedef struct packed {
		u8fnn_pkg::kind_t kind;
		logic [63:0]      bytes;
		logic [3:0]       len;
		logic             last;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_value = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [63:0] char_bytes;
	logic [3:0]  char_len;
	logic        last;

	feed_t  byte_feed_q[$];
	frame_t framed_q[$];
	feed_t  next_feed;
	frame_t got_frame;

	// Shadow of the framer state.
	logic [63:0] acc_bytes = '0;
	logic [3:0]  seq_len = '0;
	logic [3:0]  seq_count = '0;
	logic        seq_broken = 1'b0;
	logic        cr_pending = 1'b0;

	bit req_fire = 1'b0;
	bit res_fire = 1'b0;
	int send_wait = 0;
	int rx_stall = 0;
	int rx_hold = 0;
	int res_count = 0;
	int fail_count = 0;

	utf8_char_framer_newline_norm_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.char_bytes    (char_bytes),
		.char_len      (char_len),
		.last          (last)
	);

	always #5 clk = ~clk;

	function automatic frame_t make_frame(u8fnn_pkg::kind_t k, logic [63:0] b, logic [3:0] l);
		frame_t f;
		f.kind = k;
		f.bytes = b;
		f.len = l;
		f.last = 1'b0;
		return f;
	endfunction

	// Works out the results that one accepted request causes and queues them.
	task automatic frame_request(input logic [7:0] b, input logic eos);
		frame_t      made [2];
		int          n;
		int          run;
		logic [63:0] got;
		logic [3:0]  got_len;
		logic        was_bad;
		logic        is_cont;
		n = 0;
		is_cont = (b >= u8fnn_pkg::CONT_LO) && (b <= u8fnn_pkg::CONT_HI);
		if (eos) begin
			if (seq_len != 0) begin
				made[n] = make_frame(u8fnn_pkg::KIND_INVALID, '0, '0);
				n++;
			end
			made[n] = make_frame(u8fnn_pkg::KIND_END, '0, '0);
			n++;
			acc_bytes = '0;
			seq_len = '0;
			seq_count = '0;
			seq_broken = 1'b0;
			cr_pending = 1'b0;
		end else if (cr_pending && b == u8fnn_pkg::CHAR_LF) begin
			// The LF of a CR LF pair is dropped.
			cr_pending = 1'b0;
		end else begin
			cr_pending = 1'b0;
			if (seq_len != 0) begin
				// Inside a sequence: bad bytes are counted but not stored.
				if (!is_cont) begin
					seq_broken = 1'b1;
				end else if (!seq_broken && seq_count < 8) begin
					acc_bytes = acc_bytes | (64'(b) << (8 * seq_count));
				end
				seq_count = seq_count + 4'd1;
				if (seq_count >= seq_len) begin
					got = acc_bytes;
					got_len = seq_len;
					was_bad = seq_broken;
					acc_bytes = '0;
					seq_len = '0;
					seq_count = '0;
					seq_broken = 1'b0;
					if (was_bad) begin
						made[n] = make_frame(u8fnn_pkg::KIND_INVALID, '0, '0);
						n++;
					end else if (!(got_len == 4'd3 &&
							got == {40'd0, u8fnn_pkg::BOM_B2, u8fnn_pkg::BOM_B1,
								u8fnn_pkg::BOM_B0})) begin
						made[n] = make_frame(u8fnn_pkg::KIND_CHAR, got, got_len);
						n++;
					end
				end
			end else if (is_cont) begin
				// A continuation byte with no open sequence.
				made[n] = make_frame(u8fnn_pkg::KIND_INVALID, '0, '0);
				n++;
			end else if (b <= u8fnn_pkg::ASCII_MAX) begin
				if (b == u8fnn_pkg::CHAR_CR) begin
					cr_pending = 1'b1;
					made[n] = make_frame(u8fnn_pkg::KIND_NEWLINE, '0, '0);
				end else if (b == u8fnn_pkg::CHAR_LF) begin
					made[n] = make_frame(u8fnn_pkg::KIND_NEWLINE, '0, '0);
				end else begin
					made[n] = make_frame(u8fnn_pkg::KIND_CHAR, 64'(b), 4'd1);
				end
				n++;
			end else begin
				// Lead byte: the run of top ones gives the sequence length.
				run = 0;
				while (run < 8 && b[7 - run]) begin
					run++;
				end
				acc_bytes = 64'(b);
				seq_len = 4'(run);
				seq_count = 4'd1;
				seq_broken = (run > SEQ_MAX);
			end
		end
		for (int i = 0; i < n; i++) begin
			made[i].last = (i == n - 1);
			framed_q.push_back(made[i]);
		end
	endtask

	// Sender gaps: every fourth stretch of forty requests runs back to back.
	task automatic push_byte(input logic [7:0] b);
		feed_t f;
		f.value = b;
		f.eos = 1'b0;
		f.gap = ((byte_feed_q.size() / 40) % 4 == 0) ? 0 : $urandom_range(0, 5);
		byte_feed_q.push_back(f);
	endtask

	task automatic push_end();
		feed_t f;
		f.value = 8'($urandom);
		f.eos = 1'b1;
		f.gap = $urandom_range(0, 5);
		byte_feed_q.push_back(f);
	endtask

	// Reset and stimulus.
	initial begin
		int         pick;
		int         n;
		int         bad_at;
		logic [7:0] rnd;
		logic [7:0] lead;

		// Directed part: ASCII extremes, newlines, stray and bad bytes, BOM, end marks.
		push_byte(8'h00);
		push_byte(8'h7F);
		push_byte(u8fnn_pkg::CHAR_CR);
		push_byte(u8fnn_pkg::CHAR_LF);
		push_byte(u8fnn_pkg::CHAR_LF);
		push_byte(u8fnn_pkg::CHAR_CR);
		push_byte(8'h41);
		push_byte(8'hBF);
		push_byte(8'h80);
		push_byte(8'hC3);
		push_byte(8'hA9);
		push_byte(u8fnn_pkg::BOM_B0);
		push_byte(u8fnn_pkg::BOM_B1);
		push_byte(u8fnn_pkg::BOM_B2);
		push_byte(8'hE2);
		push_byte(8'h41);
		push_byte(8'h82);
		push_byte(8'hF0);
		push_end();
		push_end();

		// Random part: mostly well-formed text, some malformed input and noise.
		while (byte_feed_q.size() < 770) begin
			pick = $urandom_range(0, 99);
			n = $urandom_range(2, 8);
			lead = (8'hFF << (8 - n));
			rnd = 8'($urandom);
			lead = lead | (rnd & (8'h7F >> n));
			if (pick < 28) begin
				push_byte(8'($urandom_range(0, 127)));
			end else if (pick < 36) begin
				push_byte(u8fnn_pkg::CHAR_CR);
				push_byte(u8fnn_pkg::CHAR_LF);
			end else if (pick < 68) begin
				push_byte(lead);
				for (int i = 1; i < n; i++) begin
					push_byte(8'h80 | 8'($urandom_range(0, 63)));
				end
			end else if (pick < 73) begin
				push_byte(u8fnn_pkg::BOM_B0);
				push_byte(u8fnn_pkg::BOM_B1);
				push_byte(u8fnn_pkg::BOM_B2);
			end else if (pick < 78) begin
				push_byte(8'h80 | 8'($urandom_range(0, 63)));
			end else if (pick < 87) begin
				// One later byte of the sequence is not a continuation.
				bad_at = $urandom_range(1, n - 1);
				push_byte(lead);
				for (int i = 1; i < n; i++) begin
					rnd = 8'($urandom);
					if (i == bad_at && rnd[7:6] == 2'b10) begin
						rnd[6] = 1'b1;
					end else if (i != bad_at) begin
						rnd = 8'h80 | (rnd & 8'h3F);
					end
					push_byte(rnd);
				end
			end else if (pick < 91) begin
				// Stream ends part way into a sequence.
				push_byte(lead);
				for (int i = $urandom_range(0, n - 2); i > 0; i--) begin
					push_byte(8'h80 | 8'($urandom_range(0, 63)));
				end
				push_end();
			end else if (pick < 94) begin
				push_end();
			end else begin
				push_byte(8'($urandom));
			end
		end
		push_end();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in and every result to come out.
		while (byte_feed_q.size() != 0 || in_valid || framed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	// Driver: offers the next request once the previous one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_fire) begin
			if (byte_feed_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_wait < byte_feed_q[0].gap) begin
				send_wait++;
				in_valid <= 1'b0;
			end else begin
				next_feed = byte_feed_q.pop_front();
				send_wait = 0;
				byte_value <= next_feed.value;
				end_of_stream <= next_feed.eos;
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver: random stalls per result, calm stretches, and one long hold.
	always @(negedge clk) begin
		if (res_fire) begin
			rx_stall = ((res_count / 50) % 3 == 0) ? 0 : $urandom_range(0, 5);
			if (res_count == 150) begin
				rx_hold = 120;
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin
		req_fire = arst_n && in_valid && in_ready;
		res_fire = arst_n && out_valid && out_ready;
		if (req_fire) begin
			frame_request(byte_value, end_of_stream);
		end
		if (res_fire) begin
			res_count++;
			if (framed_q.size() == 0) begin
				$error("unexpected result: kind %0d bytes %h len %0d",
					kind, char_bytes, char_len);
				fail_count++;
			end else begin
				got_frame = framed_q.pop_front();
				if (kind !== got_frame.kind) begin
					$error("kind: expected %0d, actual %0d", got_frame.kind, kind);
					fail_count++;
				end
				if (char_bytes !== got_frame.bytes) begin
					$error("char_bytes: expected %h, actual %h", got_frame.bytes, char_bytes);
					fail_count++;
				end
				if (char_len !== got_frame.len) begin
					$error("char_len: expected %0d, actual %0d", got_frame.len, char_len);
					fail_count++;
				end
				if (last !== got_frame.last) begin
					$error("last: expected %0d, actual %0d", got_frame.last, last);
					fail_count++;
				end
			end
		end
	end

endmodule
